// File: hdl/evf_pkg.sv
package evf_pkg;

	localparam int DEPTH           = 64;
	localparam int NUM_EVENT_TYPES = 16;
	localparam int PTR_W           = $clog2(DEPTH);
	localparam int FILL_W          = $clog2(DEPTH + 1);
	localparam int ID_W            = 4;
	localparam int WORD_W          = 32;
	localparam int MON_W           = 8;

	localparam logic [1:0] KIND_PUSH  = 2'd0;
	localparam logic [1:0] KIND_POP   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_HALTED = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ID_W-1:0]   event_id;
		logic [WORD_W-1:0] aux_data;
		logic [WORD_W-1:0] timestamp;
	} evf_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   event_out;
		logic [WORD_W-1:0] aux_out;
		logic [WORD_W-1:0] time_out;
		logic [6:0]        pending;
		logic [WORD_W-1:0] stat_value;
		logic [6:0]        peak_fill;
		logic [MON_W-1:0]  halt_monitor;
	} evf_rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} evf_qop_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [FILL_W-1:0] fill;
		logic [FILL_W-1:0] peak;
		logic [FILL_W-1:0] peak_next;
	} evf_qstat_t;

endpackage

// File: hdl/evf_queue.sv
module evf_queue
	import evf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  evf_qop_t          op,
	input  logic [ID_W-1:0]   wr_event,
	input  logic [WORD_W-1:0] wr_aux,
	input  logic [WORD_W-1:0] wr_time,
	output evf_qstat_t        qstat,
	output logic [ID_W-1:0]   rd_event,
	output logic [WORD_W-1:0] rd_aux,
	output logic [WORD_W-1:0] rd_time
);

	logic [ID_W+WORD_W-1:0] ev_aux_mem [DEPTH];
	logic [WORD_W-1:0]      time_mem [DEPTH];

	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] peak_q;
	logic [FILL_W-1:0] fill_inc;

	assign fill_inc = fill_q + FILL_W'(1);

	always_comb begin
		qstat.full      = (fill_q == FILL_W'(DEPTH));
		qstat.empty     = (fill_q == '0);
		qstat.fill      = fill_q;
		qstat.peak      = peak_q;
		qstat.peak_next = (op.push && (fill_inc > peak_q)) ? fill_inc : peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			peak_q   <= '0;
		end else begin
			if (op.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (op.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (op.push && !op.pop) begin
				fill_q <= fill_inc;
			end else if (op.pop && !op.push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
			peak_q <= qstat.peak_next;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			ev_aux_mem[wr_ptr_q] <= {wr_event, wr_aux};
			time_mem[wr_ptr_q]   <= wr_time;
		end
	end

	always_ff @(posedge clk) begin
		if (op.pop) begin
			{rd_event, rd_aux} <= ev_aux_mem[rd_ptr_q];
			rd_time            <= time_mem[rd_ptr_q];
		end
	end

endmodule

// File: hdl/evf_stats.sv
module evf_stats
	import evf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              inc,
	input  logic [ID_W-1:0]   inc_id,
	input  logic [ID_W-1:0]   query_id,
	output logic [WORD_W-1:0] query_value
);

	logic [WORD_W-1:0] cnt_q [NUM_EVENT_TYPES];

	always_comb begin
		query_value = '0;
		for (int i = 0; i < NUM_EVENT_TYPES; i++) begin
			if (query_id == ID_W'(i)) begin
				query_value = cnt_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_EVENT_TYPES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (inc) begin
			for (int i = 0; i < NUM_EVENT_TYPES; i++) begin
				if ((inc_id == ID_W'(i)) || ((i == 0) && (inc_id != '0))) begin
					cnt_q[i] <= cnt_q[i] + WORD_W'(1);
				end
			end
		end
	end

endmodule

// File: hdl/event_fifo_with_statistics.sv
// channel | signals                      | accepted when
// req     | req_valid, req_stall, req    | req_valid && !req_stall
// rsp     | rsp_valid, rsp_stall, rsp    | rsp_valid && !rsp_stall
// cfg     | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// One item per cycle while req_stall is low; each result appears in the cycle
// after its item is taken, with popped data from the queue's registered read.
// Reset empties the queue, clears all counters, the peak and the halted state.
// req_stall follows rsp_stall while a result is held; a held result stays put.
module event_fifo_with_statistics
	import evf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  evf_req_t         req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output evf_rsp_t         rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [MON_W-1:0] cfg_data
);

	logic [MON_W-1:0] monitor_id_q;
	logic             halted_q;

	logic       accept;
	logic       is_push;
	logic       is_pop;
	logic       is_query;
	logic       halt_now;
	logic       halt_eff;
	evf_qop_t   qop;
	evf_qstat_t qstat;

	logic [ID_W-1:0]   rd_event;
	logic [WORD_W-1:0] rd_aux;
	logic [WORD_W-1:0] rd_time;
	logic [WORD_W-1:0] query_value;

	logic              valid_q;
	logic [1:0]        status_q;
	logic              pop_ok_q;
	logic [6:0]        pending_q;
	logic [WORD_W-1:0] stat_q;
	logic [6:0]        peak_q;
	logic [MON_W-1:0]  halt_mon_q;

	assign cfg_ready = 1'b1;
	assign req_stall = valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign is_push  = (req.kind == KIND_PUSH);
	assign is_pop   = (req.kind == KIND_POP);
	assign is_query = (req.kind == KIND_QUERY);
	assign halt_now = !halted_q && is_push && qstat.full;
	assign halt_eff = halted_q || halt_now;

	always_comb begin
		qop.push = accept && is_push && !halt_eff;
		qop.pop  = accept && is_pop && !halt_eff && !qstat.empty;
	end

	evf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (qop),
		.wr_event (req.event_id),
		.wr_aux   (req.aux_data),
		.wr_time  (req.timestamp),
		.qstat    (qstat),
		.rd_event (rd_event),
		.rd_aux   (rd_aux),
		.rd_time  (rd_time)
	);

	evf_stats u_stats (
		.clk         (clk),
		.arst_n      (arst_n),
		.inc         (qop.push),
		.inc_id      (req.event_id),
		.query_id    (req.event_id),
		.query_value (query_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_id_q <= '0;
			halted_q     <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				monitor_id_q <= cfg_data;
			end
			if (accept && halt_now) begin
				halted_q <= 1'b1;
			end
			if (accept) begin
				valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_q   <= qop.pop;
			pending_q  <= qop.pop ? 7'(qstat.fill) : '0;
			stat_q     <= (is_query && !halt_eff) ? query_value : '0;
			peak_q     <= 7'(qstat.peak_next);
			halt_mon_q <= halt_eff ? monitor_id_q : '0;
			if (halt_eff) begin
				status_q <= ST_HALTED;
			end else if (is_pop && qstat.empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	assign rsp_valid = valid_q;

	always_comb begin
		rsp.status       = status_q;
		rsp.event_out    = pop_ok_q ? rd_event : '0;
		rsp.aux_out      = pop_ok_q ? rd_aux : '0;
		rsp.time_out     = pop_ok_q ? rd_time : '0;
		rsp.pending      = pending_q;
		rsp.stat_value   = stat_q;
		rsp.peak_fill    = peak_q;
		rsp.halt_monitor = halt_mon_q;
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted state cleared without reset");

	a_halt_mon: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_HALTED) |-> (rsp.halt_monitor == '0))
		else $error("monitor id reported without halted status");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.fill <= FILL_W'(DEPTH)) && (qstat.peak >= qstat.fill))
		else $error("occupancy out of range or above peak");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted item produced no result");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import evf_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int SETTLE   = 4;
	localparam int WATCHDOG = 2000;

	typedef struct {
		bit               is_cfg;
		logic [MON_W-1:0] cfg_val;
		evf_req_t         req;
	} job_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	evf_req_t         req = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	evf_rsp_t         rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [MON_W-1:0] cfg_data = '0;

	event_fifo_with_statistics u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// queue model state
	logic [ID_W-1:0]   eq_id  [DEPTH];
	logic [WORD_W-1:0] eq_aux [DEPTH];
	logic [WORD_W-1:0] eq_ts  [DEPTH];
	logic [WORD_W-1:0] eq_cnt [NUM_EVENT_TYPES];
	logic [PTR_W-1:0]  eq_wr = '0;
	logic [PTR_W-1:0]  eq_rd = '0;
	logic [6:0]        eq_fill = '0;
	logic [6:0]        eq_peak = '0;
	bit                eq_halted = 1'b0;
	logic [MON_W-1:0]  eq_mon = '0;

	job_t     jobs[$];
	evf_rsp_t due[$];

	logic req_fire = 1'b0;
	logic cfg_fire = 1'b0;
	int   idle_cycles = 0;
	int   err_cnt = 0;
	int   drv_gap = 0;
	int   drv_calm = 0;
	int   quiet = 0;
	int   stall_left = 0;
	int   stall_calm = 0;
	int   gen_fill = 0;
	int   n_items = 0, n_rsp = 0, n_cfg = 0;
	int   n_push = 0, n_pop = 0, n_query = 0, n_empty = 0, n_halt = 0;

	initial begin
		for (int i = 0; i < NUM_EVENT_TYPES; i++)
			eq_cnt[i] = '0;
	end

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(16, 64);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic evf_rsp_t queue_step(evf_req_t q);
		evf_rsp_t r;
		r = '0;
		if (!eq_halted && q.kind == KIND_PUSH && eq_fill == DEPTH)
			eq_halted = 1'b1;
		r.peak_fill = eq_peak;
		if (eq_halted) begin
			r.status       = ST_HALTED;
			r.halt_monitor = eq_mon;
			return r;
		end
		r.status = ST_OK;
		case (q.kind)
			KIND_PUSH: begin
				eq_id[eq_wr]  = q.event_id;
				eq_aux[eq_wr] = q.aux_data;
				eq_ts[eq_wr]  = q.timestamp;
				eq_wr         = eq_wr + 1'b1;
				eq_fill       = eq_fill + 1'b1;
				if (eq_fill > eq_peak)
					eq_peak = eq_fill;
				if (q.event_id < NUM_EVENT_TYPES)
					eq_cnt[q.event_id] = eq_cnt[q.event_id] + 1'b1;
				if (q.event_id != 0)
					eq_cnt[0] = eq_cnt[0] + 1'b1;
				r.peak_fill = eq_peak;
			end
			KIND_POP: begin
				if (eq_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.event_out = eq_id[eq_rd];
					r.aux_out   = eq_aux[eq_rd];
					r.time_out  = eq_ts[eq_rd];
					r.pending   = eq_fill;
					eq_rd       = eq_rd + 1'b1;
					eq_fill     = eq_fill - 1'b1;
				end
			end
			KIND_QUERY: begin
				if (q.event_id < NUM_EVENT_TYPES)
					r.stat_value = eq_cnt[q.event_id];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// driver: inputs change at the falling edge
	always @(negedge clk) begin
		logic             nv;
		logic             ncv;
		evf_req_t         nreq;
		logic [MON_W-1:0] ncd;
		job_t             j;
		nv   = req_valid;
		ncv  = cfg_valid;
		nreq = req;
		ncd  = cfg_data;
		if (arst_n) begin
			if (req_fire)
				nv = 1'b0;
			if (cfg_fire)
				ncv = 1'b0;
			if (!nv && !ncv) begin
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (jobs.size() > 0) begin
					if (jobs[0].is_cfg) begin
						if (quiet >= SETTLE) begin
							j   = jobs.pop_front();
							ncv = 1'b1;
							ncd = j.cfg_val;
						end
					end else begin
						j       = jobs.pop_front();
						nv      = 1'b1;
						nreq    = j.req;
						drv_gap = pick_gap(drv_calm);
					end
				end
			end
			if (!nv && !ncv && due.size() == 0)
				quiet++;
			else
				quiet = 0;
		end
		req_valid <= nv;
		req       <= nreq;
		cfg_valid <= ncv;
		cfg_data  <= ncd;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
			stall_left = pick_gap(stall_calm);
		end
	end

	// monitor: sample at the rising edge
	always @(posedge clk) begin
		evf_rsp_t want;
		if (arst_n) begin
			req_fire <= req_valid && !req_stall;
			cfg_fire <= cfg_valid && cfg_ready;
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (cfg_valid && cfg_ready) begin
				eq_mon = cfg_data;
				n_cfg++;
			end
			if (rsp_valid && !rsp_stall) begin
				n_rsp++;
				if (due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h", $time, rsp);
					err_cnt++;
				end else begin
					want = due.pop_front();
					check_field("status", 64'(want.status), 64'(rsp.status));
					check_field("event_out", 64'(want.event_out), 64'(rsp.event_out));
					check_field("aux_out", 64'(want.aux_out), 64'(rsp.aux_out));
					check_field("time_out", 64'(want.time_out), 64'(rsp.time_out));
					check_field("pending", 64'(want.pending), 64'(rsp.pending));
					check_field("stat_value", 64'(want.stat_value), 64'(rsp.stat_value));
					check_field("peak_fill", 64'(want.peak_fill), 64'(rsp.peak_fill));
					check_field("halt_monitor", 64'(want.halt_monitor),
					            64'(rsp.halt_monitor));
				end
			end
			if (req_valid && !req_stall) begin
				want = queue_step(req);
				due.push_back(want);
				n_items++;
				if (want.status == ST_HALTED)
					n_halt++;
				else if (want.status == ST_EMPTY)
					n_empty++;
				else if (req.kind == KIND_PUSH)
					n_push++;
				else if (req.kind == KIND_POP)
					n_pop++;
				else if (req.kind == KIND_QUERY)
					n_query++;
			end
		end
	end

	task automatic add_item(logic [1:0] k, logic [ID_W-1:0] id, logic [WORD_W-1:0] aux,
	                        logic [WORD_W-1:0] ts);
		job_t j;
		j.is_cfg       = 1'b0;
		j.cfg_val      = '0;
		j.req.kind      = k;
		j.req.event_id  = id;
		j.req.aux_data  = aux;
		j.req.timestamp = ts;
		jobs.push_back(j);
		if (k == KIND_PUSH && gen_fill < DEPTH)
			gen_fill++;
		else if (k == KIND_POP && gen_fill > 0)
			gen_fill--;
	endtask

	task automatic add_rand(logic [1:0] k);
		add_item(k, ID_W'($urandom_range(0, 15)), $urandom, $urandom);
	endtask

	task automatic add_cfg(logic [MON_W-1:0] v);
		job_t j;
		j.is_cfg  = 1'b1;
		j.cfg_val = v;
		j.req     = '0;
		jobs.push_back(j);
	endtask

	initial begin
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int         r;
		int         push_pct;
		logic [1:0] k;

		add_cfg(8'hFF);
		add_item(KIND_POP, 4'd0, '0, '0);
		add_item(KIND_QUERY, 4'd0, '0, '0);
		add_item(KIND_QUERY, 4'd15, '1, '1);
		add_item(KIND_SPARE, 4'd9, 32'h1234_5678, 32'h9ABC_DEF0);
		add_item(KIND_PUSH, 4'd0, 32'h0000_0000, 32'h0000_0000);
		add_item(KIND_PUSH, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(KIND_PUSH, 4'd5, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		add_item(KIND_PUSH, 4'd0, 32'h8000_0001, 32'h7FFF_FFFE);
		add_item(KIND_QUERY, 4'd0, '0, '0);
		add_item(KIND_QUERY, 4'd15, '0, '0);
		add_item(KIND_QUERY, 4'd5, '0, '0);
		add_item(KIND_QUERY, 4'd3, '0, '0);
		add_item(KIND_POP, 4'd0, '0, '0);
		add_item(KIND_POP, 4'd15, '1, '1);
		add_item(KIND_POP, 4'd0, '0, '0);
		add_item(KIND_POP, 4'd0, '0, '0);
		add_item(KIND_POP, 4'd0, '0, '0);
		add_item(KIND_SPARE, 4'd15, '1, '1);
		add_item(KIND_SPARE, 4'd0, '0, '0);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 2)
				add_cfg(8'h00);
			else if (ph == 5)
				add_cfg(8'hFF);
			else
				add_cfg(MON_W'($urandom_range(0, 255)));
			push_pct = (ph % 3 == 0) ? 75 : ((ph % 3 == 1) ? 30 : 55);
			for (int n = 0; n < 100; n++) begin
				r = $urandom_range(0, 99);
				if (r < push_pct)
					k = (gen_fill >= DEPTH) ? KIND_POP : KIND_PUSH;
				else if (r < 88)
					k = KIND_POP;
				else if (r < 97)
					k = KIND_QUERY;
				else
					k = KIND_SPARE;
				add_rand(k);
			end
		end

		// fill to the brim, pop at full, refill, then overflow into the halted state
		add_cfg(MON_W'($urandom_range(1, 254)));
		while (gen_fill < DEPTH)
			add_rand(KIND_PUSH);
		add_rand(KIND_POP);
		add_rand(KIND_PUSH);
		for (int i = 0; i < NUM_EVENT_TYPES; i++)
			add_item(KIND_QUERY, ID_W'(i), $urandom, $urandom);
		add_rand(KIND_PUSH);
		add_rand(KIND_POP);
		add_rand(KIND_QUERY);
		add_rand(KIND_SPARE);
		add_rand(KIND_PUSH);
		add_cfg(8'hFF);
		add_rand(KIND_POP);
		add_rand(KIND_QUERY);
		add_cfg(8'h00);
		add_rand(KIND_PUSH);
		add_rand(KIND_POP);

		repeat (10) @(posedge clk);
		#3 arst_n = 1'b1;

		while (jobs.size() != 0 || req_valid || cfg_valid)
			@(posedge clk);
		while (due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d items and %0d results: %0d pushes, %0d pops, %0d queries,",
		         n_items, n_rsp, n_push, n_pop, n_query);
		$display("%0d pops on empty, %0d halted results, %0d monitor id writes, peak fill %0d",
		         n_empty, n_halt, n_cfg, eq_peak);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: event_fifo_with_statistics.f
hdl/evf_pkg.sv
hdl/evf_queue.sv
hdl/evf_stats.sv
hdl/event_fifo_with_statistics.sv
sim/tb.sv
